### rtl/trfr_pkg.sv
// ----------------------------------------------------------------------------
// Token ring frame receiver package
// Result kinds, queue entry layout, sizes and register indexes shared by the
// front end, the result queue and the back end.
// ----------------------------------------------------------------------------
package trfr_pkg;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_TOKEN = 3'd0,
      KIND_TIME  = 3'd1,
      KIND_CHAT  = 3'd2,
      KIND_LINE  = 3'd3,
      KIND_BACK  = 3'd4
   } kind_type;

   // Frame constants
   localparam logic [7:0] TOKEN_BYTE     = 8'hFF;
   localparam logic [3:0] BROADCAST_ADDR = 4'hF;
   localparam logic [3:0] TOKEN_ADDR     = 4'hF;
   localparam logic [2:0] TOKEN_SAPI     = 3'h7;

   // Configuration port
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 4;
   localparam logic [CsrIdxW-1:0] CSR_STATION_ADDR = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_CHAT_ENABLED = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_TIME_SVC     = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_CHAT_SVC     = 2'd3;

   // Stream widths
   localparam int ReqDataW = 8;
   localparam int ReqUserW = 1;
   localparam int RspDataW = 24;
   localparam int RspUserW = 3;

   // Result queue
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // One queue entry: all results caused by one byte (one or two)
   typedef struct packed {
      logic       two;
      kind_type   kind0;
      kind_type   kind1;
      logic [3:0] src_addr;
      logic [2:0] src_sapi;
      logic [7:0] length;
      logic [7:0] status;
   } entry_type;

   // Queue status seen by its producer and consumer
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

### rtl/trfr_front.sv
// ----------------------------------------------------------------------------
// Token ring frame receiver front end
// Holds the configuration registers, tracks frame position and running sum,
// classifies each byte and hands its results to the queue as one entry.
// ----------------------------------------------------------------------------
module trfr_front
   import trfr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   input  logic                accept,
   input  logic [7:0]          frame_byte,
   input  logic                frame_start,
   output logic                push,
   output entry_type           push_entry
);

   logic [3:0] station_ff;
   logic       chat_en_ff;
   logic [2:0] time_svc_ff;
   logic [2:0] chat_svc_ff;

   logic [8:0] pos_ff, pos_in, pos;
   logic [7:0] sum_ff, sum_in, sum;
   logic       skip_ff, skip_in, skip;
   logic [7:0] src_ff, src_in;
   logic [7:0] dst_ff, dst_in;
   logic [7:0] len_ff, len_in;

   logic       emit;
   logic       match, good, from_self, has_ind;
   kind_type   ind;
   logic [7:0] status;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         station_ff  <= 4'd1;
         chat_en_ff  <= 1'b1;
         time_svc_ff <= 3'd1;
         chat_svc_ff <= 3'd3;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_STATION_ADDR: station_ff  <= csr_wdata[3:0];
            CSR_CHAT_ENABLED: chat_en_ff  <= csr_wdata[0];
            CSR_TIME_SVC:     time_svc_ff <= csr_wdata[2:0];
            CSR_CHAT_SVC:     chat_svc_ff <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   // Classify the incoming byte and work out the next frame state
   always_comb begin
      pos    = frame_start ? 9'd0 : pos_ff;
      sum    = frame_start ? 8'd0 : sum_ff;
      skip   = frame_start ? 1'b0 : skip_ff;
      pos_in  = pos;
      sum_in  = sum;
      skip_in = skip;
      src_in  = src_ff;
      dst_in  = dst_ff;
      len_in  = len_ff;
      emit       = 1'b0;
      match      = 1'b0;
      good       = 1'b0;
      from_self  = 1'b0;
      has_ind    = 1'b0;
      ind        = KIND_TIME;
      status     = frame_byte;
      push_entry = '{two: 1'b0, kind0: KIND_TOKEN, kind1: KIND_TOKEN,
                     src_addr: TOKEN_ADDR, src_sapi: TOKEN_SAPI,
                     length: 8'd0, status: 8'd0};

      if (!skip) begin
         if (pos == 9'd0 && frame_byte == TOKEN_BYTE) begin
            // token: one result, then drop the rest of the frame
            src_in  = TOKEN_BYTE;
            len_in  = 8'd0;
            skip_in = 1'b1;
            emit    = 1'b1;
         end else begin
            if (pos == 9'd0) src_in = frame_byte;
            if (pos == 9'd1) dst_in = frame_byte;
            if (pos == 9'd2) len_in = frame_byte;

            if ({1'b0, pos} < ({2'b00, len_in} + 10'd3)) begin
               // header or payload: accumulate
               sum_in = sum + frame_byte;
               pos_in = pos + 9'd1;
            end else begin
               // status byte: check the frame
               skip_in   = 1'b1;
               from_self = (src_in[6:3] == station_ff);
               match     = (dst_in[6:3] == station_ff) || (dst_in[6:3] == BROADCAST_ADDR);
               good      = (sum[5:0] == frame_byte[7:2]);
               if (dst_in[2:0] == time_svc_ff) begin
                  has_ind = 1'b1;
                  ind     = KIND_TIME;
               end else if (dst_in[2:0] == chat_svc_ff && chat_en_ff) begin
                  has_ind = 1'b1;
                  ind     = KIND_CHAT;
               end

               if (match) begin
                  emit = 1'b1;
                  if (good) begin
                     status[0] = 1'b1;
                     if (has_ind) begin
                        status[1]        = 1'b1;
                        push_entry.two   = 1'b1;
                        push_entry.kind0 = ind;
                        push_entry.kind1 = from_self ? KIND_BACK : KIND_LINE;
                     end else begin
                        push_entry.two   = from_self;
                        push_entry.kind0 = KIND_LINE;
                        push_entry.kind1 = KIND_BACK;
                     end
                  end else begin
                     status[1]        = 1'b1;
                     push_entry.two   = from_self;
                     push_entry.kind0 = KIND_LINE;
                     push_entry.kind1 = KIND_BACK;
                  end
               end else if (from_self) begin
                  emit             = 1'b1;
                  push_entry.kind0 = KIND_BACK;
               end
               push_entry.src_addr = src_in[6:3];
               push_entry.src_sapi = src_in[2:0];
               push_entry.length   = len_in;
               push_entry.status   = status;
            end
         end
      end
   end

   assign push = accept && emit;

   // Frame state, advanced on every accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 9'd0;
         sum_ff  <= 8'd0;
         skip_ff <= 1'b1;
         src_ff  <= 8'd0;
         dst_ff  <= 8'd0;
         len_ff  <= 8'd0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         sum_ff  <= sum_in;
         skip_ff <= skip_in;
         src_ff  <= src_in;
         dst_ff  <= dst_in;
         len_ff  <= len_in;
      end
   end

endmodule

### rtl/trfr_queue.sv
// ----------------------------------------------------------------------------
// Token ring frame receiver result queue
// Short first-in first-out queue of result entries between front and back.
// ----------------------------------------------------------------------------
module trfr_queue
   import trfr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  entry_type      push_entry,
   input  logic           pop,
   output entry_type      pop_entry,
   output queue_stat_type stat
);

   entry_type            mem_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff;
   logic [QueuePtrW-1:0] rd_ptr_ff;
   logic [QueueCntW-1:0] count_ff;
   logic                 do_push, do_pop;

   assign stat.full  = (count_ff == QueueCntW'(QueueDepth));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

### rtl/trfr_back.sv
// ----------------------------------------------------------------------------
// Token ring frame receiver back end
// Splits each queue entry into one or two results and drives the output
// register of the result stream.
// ----------------------------------------------------------------------------
module trfr_back
   import trfr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  entry_type      pop_entry,
   input  queue_stat_type stat,
   output logic           pop,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,
   output logic [RspUserW-1:0] rsp_tuser,
   output logic           rsp_tlast
);

   logic       out_valid_ff;
   kind_type   out_kind_ff;
   logic [3:0] out_addr_ff;
   logic [2:0] out_sapi_ff;
   logic [7:0] out_len_ff;
   logic [7:0] out_status_ff;
   logic       out_last_ff;

   logic       pend_valid_ff;
   kind_type   pend_kind_ff;
   logic [3:0] pend_addr_ff;
   logic [2:0] pend_sapi_ff;
   logic [7:0] pend_len_ff;
   logic [7:0] pend_status_ff;

   logic load;

   assign load = !out_valid_ff || rsp_tready;
   assign pop  = load && !pend_valid_ff && !stat.empty;

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else if (load) begin
         if (pend_valid_ff) begin
            out_valid_ff  <= 1'b1;
            pend_valid_ff <= 1'b0;
         end else if (!stat.empty) begin
            out_valid_ff  <= 1'b1;
            pend_valid_ff <= pop_entry.two;
         end else begin
            out_valid_ff  <= 1'b0;
         end
      end
   end

   // Result payload: take the held second result first, else the queue head
   always_ff @(posedge clock) begin
      if (load) begin
         if (pend_valid_ff) begin
            out_kind_ff   <= pend_kind_ff;
            out_addr_ff   <= pend_addr_ff;
            out_sapi_ff   <= pend_sapi_ff;
            out_len_ff    <= pend_len_ff;
            out_status_ff <= pend_status_ff;
            out_last_ff   <= 1'b1;
         end else begin
            out_kind_ff    <= pop_entry.kind0;
            out_addr_ff    <= pop_entry.src_addr;
            out_sapi_ff    <= pop_entry.src_sapi;
            out_len_ff     <= pop_entry.length;
            out_status_ff  <= pop_entry.status;
            out_last_ff    <= !pop_entry.two;
            pend_kind_ff   <= pop_entry.kind1;
            pend_addr_ff   <= pop_entry.src_addr;
            pend_sapi_ff   <= pop_entry.src_sapi;
            pend_len_ff    <= pop_entry.length;
            pend_status_ff <= pop_entry.status;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {1'b0, out_status_ff, out_len_ff, out_sapi_ff, out_addr_ff};

endmodule

### rtl/token_ring_frame_receiver.sv
// ----------------------------------------------------------------------------
// Token ring frame receiver
// Takes a frame one byte per transaction, checks it at its status byte and
// reports token, indication, to-line and databack results.
// ----------------------------------------------------------------------------
// The receiver accepts one byte every clock cycle as long as its four-entry
// result queue has room; a byte's classification is done in the cycle it is
// accepted. Each token byte, and each status byte of a frame that is addressed
// to this station or broadcast or was sent by it, places one queue entry
// holding one or two results, and the back end delivers one result per cycle
// from its output register while rsp_tready is high. Configuration registers
// are to be written through csr_we/csr_index/csr_wdata only while the receiver
// is idle; the user must ensure this, as the block does not enforce it.
module token_ring_frame_receiver
   import trfr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // configuration
   input  logic                csr_we,
   input  logic [CsrIdxW-1:0]  csr_index,
   input  logic [CsrDataW-1:0] csr_wdata,
   // byte stream
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [ReqDataW-1:0] req_tdata,   // [7:0] frame_byte
   input  logic [ReqUserW-1:0] req_tuser,   // [0] frame_start
   // result stream
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RspDataW-1:0] rsp_tdata,   // [3:0] source_address, [6:4] source_sapi,
                                            // [14:7] payload_length, [22:15] status_byte,
                                            // [23] zero
   output logic [RspUserW-1:0] rsp_tuser,   // [2:0] result_kind
   output logic                rsp_tlast    // last_of_run
);

   logic           accept;
   logic           push;
   logic           pop;
   entry_type      push_entry;
   entry_type      pop_entry;
   queue_stat_type stat;

   // Accept while the queue has room
   assign req_tready = !stat.full;
   assign accept     = req_tvalid && req_tready;

   trfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .accept      (accept),
      .frame_byte  (req_tdata[7:0]),
      .frame_start (req_tuser[0]),
      .push        (push),
      .push_entry  (push_entry)
   );

   trfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .stat       (stat)
   );

   trfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_entry  (pop_entry),
      .stat       (stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
